@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, reset included.
`define SBT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("sbt assertion failed");

// Checked only outside reset.
`define SBT_ASSERT_RUN(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("sbt assertion failed");

`endif

@@ rtl/sbt_pkg.sv @@
package sbt_pkg;

   localparam int OFFSET_BITS   = 24;
   localparam int KEYWORD_BYTES = 8;
   localparam int MAX_NESTING   = 255;
   localparam int QDEPTH        = 4;
   localparam int QPTR_BITS     = $clog2(QDEPTH);
   localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

   localparam logic [5:0] K_LBRACE = 6'd0, K_RBRACE = 6'd1, K_LBRACKET = 6'd2,
      K_RBRACKET = 6'd3, K_LPAREN = 6'd4, K_RPAREN = 6'd5, K_COMMA = 6'd6,
      K_COLON = 6'd7, K_DOT = 6'd8, K_AT = 6'd9, K_TILDE = 6'd10, K_SEMI = 6'd11,
      K_PLUS = 6'd12, K_MINUS = 6'd13, K_STAR = 6'd14, K_SLASH = 6'd15,
      K_CLASS = 6'd16, K_ELSE = 6'd17, K_FI = 6'd18, K_IF = 6'd19, K_IN = 6'd20,
      K_INHERITS = 6'd21, K_ISVOID = 6'd22, K_LET = 6'd23, K_LOOP = 6'd24,
      K_POOL = 6'd25, K_THEN = 6'd26, K_WHILE = 6'd27, K_CASE = 6'd28,
      K_ESAC = 6'd29, K_NEW = 6'd30, K_OF = 6'd31, K_NOT = 6'd32, K_BOOL = 6'd33,
      K_TYPEID = 6'd34, K_OBJID = 6'd35, K_INT = 6'd36, K_STR = 6'd37,
      K_LE = 6'd38, K_ASSIGN = 6'd39, K_LT = 6'd40, K_DARROW = 6'd41,
      K_EQUAL = 6'd42, K_GE = 6'd43, K_GT = 6'd44, K_ERROR = 6'd45, K_END = 6'd46;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic [5:0]             kind;
      logic [OFFSET_BITS-1:0] offset;
      logic [15:0]            line;
      logic [15:0]            column;
      logic [15:0]            length;
      logic                   last;
   } token_type;

   typedef struct packed {
      logic      valid0;
      logic      valid1;
      token_type tok0;
      token_type tok1;
   } push_type;

   function automatic logic [15:0] sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "[": k = K_LBRACKET;
         "]": k = K_RBRACKET;
         ")": k = K_RPAREN;
         ",": k = K_COMMA;
         ":": k = K_COLON;
         ".": k = K_DOT;
         "@": k = K_AT;
         "~": k = K_TILDE;
         ";": k = K_SEMI;
         "+": k = K_PLUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

   // The prefix holds the first characters of a word, the latest in the low byte.
   function automatic logic [5:0] word_kind(input logic [8*KEYWORD_BYTES-1:0] w,
                                           input logic [15:0] n, input logic upper);
      logic [5:0] k;
      k = upper ? K_TYPEID : K_OBJID;
      if      (n == 16'd5 && w == 64'("class"))    k = K_CLASS;
      else if (n == 16'd4 && w == 64'("else"))     k = K_ELSE;
      else if (n == 16'd2 && w == 64'("fi"))       k = K_FI;
      else if (n == 16'd2 && w == 64'("if"))       k = K_IF;
      else if (n == 16'd2 && w == 64'("in"))       k = K_IN;
      else if (n == 16'd8 && w == 64'("inherits")) k = K_INHERITS;
      else if (n == 16'd6 && w == 64'("isvoid"))   k = K_ISVOID;
      else if (n == 16'd3 && w == 64'("let"))      k = K_LET;
      else if (n == 16'd4 && w == 64'("loop"))     k = K_LOOP;
      else if (n == 16'd4 && w == 64'("pool"))     k = K_POOL;
      else if (n == 16'd4 && w == 64'("then"))     k = K_THEN;
      else if (n == 16'd5 && w == 64'("while"))    k = K_WHILE;
      else if (n == 16'd4 && w == 64'("case"))     k = K_CASE;
      else if (n == 16'd4 && w == 64'("esac"))     k = K_ESAC;
      else if (n == 16'd3 && w == 64'("new"))      k = K_NEW;
      else if (n == 16'd2 && w == 64'("of"))       k = K_OF;
      else if (n == 16'd3 && w == 64'("not"))      k = K_NOT;
      else if (n == 16'd4 && w == 64'("true"))     k = K_BOOL;
      else if (n == 16'd5 && w == 64'("false"))    k = K_BOOL;
      return k;
   endfunction

endpackage

@@ rtl/sbt_scan.sv @@
// Front end: classifies each byte and produces up to two tokens per byte.
module sbt_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           text_byte,
   output sbt_pkg::push_type    push
);

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_STR, M_LT, M_EQ, M_GT, M_MINUS, M_LPAR,
      M_LCMT, M_BCMT
   } mode_type;

   localparam int OB = sbt_pkg::OFFSET_BITS;
   localparam int PB = 8 * sbt_pkg::KEYWORD_BYTES;

   mode_type          mode_ff, mode_in;
   logic              hold_paren_ff, hold_paren_in, hold_star_ff, hold_star_in;
   logic [7:0]        depth_ff, depth_in;
   logic [15:0]       line_ff, line_in, col_ff, col_in;
   logic [OB-1:0]     off_ff, off_in;
   logic [15:0]       sline_ff, sline_in, scol_ff, scol_in;
   logic [OB-1:0]     soff_ff, soff_in;
   logic [15:0]       run_ff, run_in;
   logic [PB-1:0]     prefix_ff, prefix_in;
   logic              upper_ff, upper_in, esc_ff, esc_in;

   logic                 a_v, b_v, fl_v, used;
   logic [5:0]           fl_kind;
   logic [15:0]          fl_len;
   sbt_pkg::token_type   a_tok, b_tok;
   logic [7:0]           c;

   assign c = text_byte;

   always_comb begin
      fl_v    = 1'b1;
      fl_kind = sbt_pkg::K_ERROR;
      fl_len  = 16'd1;
      unique case (mode_ff)
         M_IDENT: begin
            fl_kind = sbt_pkg::word_kind(prefix_ff, run_ff, upper_ff);
            fl_len  = run_ff;
         end
         M_INT: begin
            fl_kind = sbt_pkg::K_INT;
            fl_len  = run_ff;
         end
         M_STR:   fl_len  = run_ff;
         M_LT:    fl_kind = sbt_pkg::K_LT;
         M_EQ:    fl_kind = sbt_pkg::K_EQUAL;
         M_GT:    fl_kind = sbt_pkg::K_GT;
         M_MINUS: fl_kind = sbt_pkg::K_MINUS;
         M_LPAR:  fl_kind = sbt_pkg::K_LPAREN;
         default: fl_v    = 1'b0;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      hold_paren_in = hold_paren_ff;
      hold_star_in  = hold_star_ff;
      depth_in      = depth_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      off_in        = off_ff;
      sline_in      = sline_ff;
      scol_in       = scol_ff;
      soff_in       = soff_ff;
      run_in        = run_ff;
      prefix_in     = prefix_ff;
      upper_in      = upper_ff;
      esc_in        = esc_ff;
      used          = 1'b1;
      a_v           = 1'b0;
      b_v           = 1'b0;
      a_tok         = '{kind: fl_kind, offset: soff_ff, line: sline_ff, column: scol_ff,
                        length: fl_len, last: 1'b0};
      b_tok         = '{kind: sbt_pkg::K_END, offset: off_ff, line: line_ff, column: col_ff,
                        length: 16'd0, last: 1'b1};

      if (c == 8'd0) begin
         if (mode_ff == M_BCMT) begin
            a_v   = 1'b1;
            a_tok = '{kind: sbt_pkg::K_ERROR, offset: off_ff, line: line_ff, column: col_ff,
                      length: 16'd0, last: 1'b0};
         end else begin
            a_v = fl_v;
         end
         b_v           = 1'b1;
         mode_in       = M_IDLE;
         hold_paren_in = 1'b0;
         hold_star_in  = 1'b0;
         depth_in      = '0;
         line_in       = 16'd1;
         col_in        = 16'd1;
         off_in        = '0;
         sline_in      = 16'd1;
         scol_in       = 16'd1;
         soff_in       = '0;
         run_in        = '0;
         esc_in        = 1'b0;
      end else begin
         unique case (mode_ff)
            M_IDENT: begin
               if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c) || c == "_") begin
                  if (run_ff < 16'(sbt_pkg::KEYWORD_BYTES))
                     prefix_in = {prefix_ff[PB-9:0], c};
                  run_in = sbt_pkg::sat16(run_ff);
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_INT: begin
               if (sbt_pkg::is_digit(c)) begin
                  run_in = sbt_pkg::sat16(run_ff);
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  run_in = sbt_pkg::sat16(run_ff);
               end else if (c == "\"") begin
                  a_v          = 1'b1;
                  a_tok.kind   = sbt_pkg::K_STR;
                  a_tok.length = sbt_pkg::sat16(run_ff);
                  mode_in      = M_IDLE;
               end else if (c == "\n") begin
                  a_v  = fl_v;
                  used = 1'b0;
               end else begin
                  esc_in = (c == sbt_pkg::CH_BACKSLASH);
                  run_in = sbt_pkg::sat16(run_ff);
               end
            end
            M_LT: begin
               if (c == "=" || c == "-") begin
                  a_v          = 1'b1;
                  a_tok.kind   = (c == "=") ? sbt_pkg::K_LE : sbt_pkg::K_ASSIGN;
                  a_tok.length = 16'd2;
                  mode_in      = M_IDLE;
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_EQ, M_GT: begin
               if ((mode_ff == M_EQ && c == ">") || (mode_ff == M_GT && c == "=")) begin
                  a_v          = 1'b1;
                  a_tok.kind   = (mode_ff == M_EQ) ? sbt_pkg::K_DARROW : sbt_pkg::K_GE;
                  a_tok.length = 16'd2;
                  mode_in      = M_IDLE;
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_MINUS: begin
               if (c == "-") begin
                  mode_in = M_LCMT;
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_LPAR: begin
               if (c == "*") begin
                  mode_in       = M_BCMT;
                  depth_in      = 8'd1;
                  hold_paren_in = 1'b0;
                  hold_star_in  = 1'b0;
               end else begin
                  a_v  = fl_v;
                  used = 1'b0;
               end
            end
            M_LCMT: begin
               if (c == "\n")
                  mode_in = M_IDLE;
            end
            M_BCMT: begin
               hold_paren_in = 1'b0;
               hold_star_in  = 1'b0;
               if (hold_paren_ff && c == "*") begin
                  if (depth_ff < 8'(sbt_pkg::MAX_NESTING))
                     depth_in = depth_ff + 8'd1;
               end else if (hold_star_ff && c == ")") begin
                  depth_in = (depth_ff != 8'd0) ? depth_ff - 8'd1 : depth_ff;
                  if (depth_in == 8'd0)
                     mode_in = M_IDLE;
               end else begin
                  hold_paren_in = (c == "(");
                  hold_star_in  = (c == "*");
               end
            end
            default: used = 1'b0;
         endcase

         if (!used) begin
            mode_in  = M_IDLE;
            sline_in = line_ff;
            scol_in  = col_ff;
            soff_in  = off_ff;
            if (sbt_pkg::is_alpha(c)) begin
               mode_in   = M_IDENT;
               prefix_in = {{(PB-8){1'b0}}, c};
               upper_in  = (c >= "A" && c <= "Z");
               run_in    = 16'd1;
            end else if (sbt_pkg::is_digit(c)) begin
               mode_in = M_INT;
               run_in  = 16'd1;
            end else if (c == "\"") begin
               mode_in = M_STR;
               run_in  = 16'd1;
               esc_in  = 1'b0;
            end else if (c == "<") begin
               mode_in = M_LT;
            end else if (c == "=") begin
               mode_in = M_EQ;
            end else if (c == ">") begin
               mode_in = M_GT;
            end else if (c == "-") begin
               mode_in = M_MINUS;
            end else if (c == "(") begin
               mode_in = M_LPAR;
            end else if (c != " " && c != "\t" && c != "\n") begin
               b_v          = 1'b1;
               b_tok.kind   = sbt_pkg::single_kind(c);
               b_tok.length = 16'd1;
            end
         end

         off_in = off_ff + OB'(1);
         if (c == "\n") begin
            line_in = sbt_pkg::sat16(line_ff);
            col_in  = 16'd1;
         end else begin
            col_in = sbt_pkg::sat16(col_ff);
         end
      end
   end

   always_comb begin
      push.valid0    = take & (a_v | b_v);
      push.valid1    = take & a_v & b_v;
      push.tok0      = a_v ? a_tok : b_tok;
      push.tok0.last = ~(a_v & b_v);
      push.tok1      = b_tok;
   end

   // The word prefix has no reset; only characters already stored are compared.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         hold_paren_ff <= 1'b0;
         hold_star_ff  <= 1'b0;
         depth_ff      <= '0;
         line_ff       <= 16'd1;
         col_ff        <= 16'd1;
         off_ff        <= '0;
         sline_ff      <= 16'd1;
         scol_ff       <= 16'd1;
         soff_ff       <= '0;
         run_ff        <= '0;
         upper_ff      <= 1'b0;
         esc_ff        <= 1'b0;
      end else if (take) begin
         mode_ff       <= mode_in;
         hold_paren_ff <= hold_paren_in;
         hold_star_ff  <= hold_star_in;
         depth_ff      <= depth_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         off_ff        <= off_in;
         sline_ff      <= sline_in;
         scol_ff       <= scol_in;
         soff_ff       <= soff_in;
         run_ff        <= run_in;
         prefix_ff     <= prefix_in;
         upper_ff      <= upper_in;
         esc_ff        <= esc_in;
      end
   end

endmodule

@@ rtl/sbt_queue.sv @@
// Token queue: up to two writes and one read per cycle.
module sbt_queue (
   input  logic                clock,
   input  logic                reset,
   input  sbt_pkg::push_type   push,
   input  logic                pop,
   output logic                not_empty,
   output logic                almost_full,
   output sbt_pkg::token_type  head
);

   localparam int PW = sbt_pkg::QPTR_BITS;
   localparam int CW = sbt_pkg::QCNT_BITS;

   sbt_pkg::token_type       mem_ff [sbt_pkg::QDEPTH];
   logic [PW-1:0]            wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]            cnt_ff, cnt_in;

   assign not_empty   = (cnt_ff != '0);
   assign almost_full = (cnt_ff > CW'(sbt_pkg::QDEPTH - 2));
   assign head        = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + PW'(push.valid0) + PW'(push.valid1);
      rp_in  = rp_ff + PW'(pop);
      cnt_in = cnt_ff + CW'(push.valid0) + CW'(push.valid1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0)
         mem_ff[wp_ff] <= push.tok0;
      if (push.valid1)
         mem_ff[wp_ff + PW'(1)] <= push.tok1;
   end

endmodule

@@ rtl/sbt_emit.sv @@
// Back end: output register that drains the queue one beat at a time.
module sbt_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  sbt_pkg::token_type  head,
   output logic                pop,
   input  logic                out_stall,
   output logic                out_valid,
   output sbt_pkg::token_type  out_tok
);

   logic               valid_ff, valid_in;
   sbt_pkg::token_type tok_ff;

   assign pop       = not_empty & (~valid_ff | ~out_stall);
   assign valid_in  = pop | (valid_ff & out_stall);
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop)
         tok_ff <= head;
   end

endmodule

@@ rtl/source_byte_tokenizer.sv @@
// Source text tokenizer for a small object language.
// Input channel (req_): one source byte per beat; a zero byte ends the text,
// flushes any pending token, emits an end token and rewinds the position to
// offset 0, line 1, column 1.
// Result channel (rsp_): one token per beat with its kind, start offset, line,
// column and length; rsp_last_of_run marks the last token caused by one byte.
// A byte yields zero, one or two tokens.
// Throughput: one byte per cycle while the token queue has room for two more
// tokens; the result side drains one token per cycle while rsp_stall is low, so
// sustained rate is bounded by that single output register.
// Path: a token caused by an accepted byte is written into the token queue,
// then loaded into the output register that drives rsp_.
// Reset (synchronous) clears the scanner to the idle mode, empties the queue
// and drops rsp_valid. When the receiver stalls, the held beat stays on the
// ports, the queue fills, and req_stall rises once fewer than two slots remain.
module source_byte_tokenizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_text_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [5:0]                       rsp_token_kind,
   output logic [sbt_pkg::OFFSET_BITS-1:0]  rsp_token_offset,
   output logic [15:0]                      rsp_token_line,
   output logic [15:0]                      rsp_token_column,
   output logic [15:0]                      rsp_token_length,
   output logic                             rsp_last_of_run
);

   sbt_pkg::push_type   push;
   sbt_pkg::token_type  head, out_tok;
   logic                take, not_empty, almost_full, pop;

   // The scanner only advances on an accepted beat.
   assign req_stall = almost_full;
   assign take      = req_valid & ~almost_full;

   sbt_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .text_byte (req_text_byte),
      .push      (push)
   );

   sbt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (pop),
      .not_empty   (not_empty),
      .almost_full (almost_full),
      .head        (head)
   );

   sbt_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_tok   (out_tok)
   );

   // Unpack the registered token onto the result ports.
   assign rsp_token_kind   = out_tok.kind;
   assign rsp_token_offset = out_tok.offset;
   assign rsp_token_line   = out_tok.line;
   assign rsp_token_column = out_tok.column;
   assign rsp_token_length = out_tok.length;
   assign rsp_last_of_run  = out_tok.last;

endmodule

@@ rtl/sbt_checker.sv @@
`include "assert_macros.svh"

module sbt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [5:0]                       rsp_token_kind,
   input logic [15:0]                      rsp_token_line,
   input logic [15:0]                      rsp_token_column,
   input logic [15:0]                      rsp_token_length,
   input logic                             rsp_last_of_run
);

   `SBT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)
   `SBT_ASSERT_RUN(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind))
   `SBT_ASSERT_RUN(a_end_last, clock, reset, rsp_valid && rsp_token_kind == sbt_pkg::K_END |-> rsp_last_of_run && rsp_token_length == 16'd0)
   `SBT_ASSERT_RUN(a_pos_nonzero, clock, reset, rsp_valid |-> rsp_token_line != 16'd0 && rsp_token_column != 16'd0)

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_line   (rsp_token_line),
   .rsp_token_column (rsp_token_column),
   .rsp_token_length (rsp_token_length),
   .rsp_last_of_run  (rsp_last_of_run)
);

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Bytes of source text are fed in one beat at a time. A small lexer model
   // inside the scoreboard predicts the tokens each accepted byte produces, and
   // every token beat that leaves the block is checked in order against them.
   class token_scoreboard;
      typedef enum {S_IDLE, S_IDENT, S_INT, S_STR, S_LT, S_EQ, S_GT, S_MINUS,
                    S_LPAR, S_LINE, S_BLOCK} scan_type;

      sbt_pkg::token_type pending_tokens[$];
      sbt_pkg::token_type made[$];
      int          errors;
      int          byte_count;
      int          token_count;

      scan_type    mode;
      logic [7:0]  held;
      int          depth;
      logic [15:0] line, col, sline, scol, run;
      logic [23:0] off, soff;
      logic [7:0]  prefix [8];
      bit          esc;

      function new();
         clear();
      endfunction

      function void clear();
         mode = S_IDLE; held = 0; depth = 0;
         line = 1; col = 1; off = 0; sline = 1; scol = 1; soff = 0;
         run = 0; esc = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function void mark();
         sline = line; scol = col; soff = off;
      endfunction

      function void emit(logic [5:0] k, logic [15:0] len);
         sbt_pkg::token_type t;
         if (made.size() >= 2) return;
         t.kind = k; t.offset = soff; t.line = sline; t.column = scol;
         t.length = len; t.last = 0;
         made.push_back(t);
      endfunction

      function logic [5:0] classify_word();
         string w;
         logic [5:0] k;
         w = "";
         if (run <= 8)
            for (int i = 0; i < run; i++) w = {w, string'(prefix[i])};
         case (w)
            "class":    k = sbt_pkg::K_CLASS;
            "else":     k = sbt_pkg::K_ELSE;
            "fi":       k = sbt_pkg::K_FI;
            "if":       k = sbt_pkg::K_IF;
            "in":       k = sbt_pkg::K_IN;
            "inherits": k = sbt_pkg::K_INHERITS;
            "isvoid":   k = sbt_pkg::K_ISVOID;
            "let":      k = sbt_pkg::K_LET;
            "loop":     k = sbt_pkg::K_LOOP;
            "pool":     k = sbt_pkg::K_POOL;
            "then":     k = sbt_pkg::K_THEN;
            "while":    k = sbt_pkg::K_WHILE;
            "case":     k = sbt_pkg::K_CASE;
            "esac":     k = sbt_pkg::K_ESAC;
            "new":      k = sbt_pkg::K_NEW;
            "of":       k = sbt_pkg::K_OF;
            "not":      k = sbt_pkg::K_NOT;
            "true", "false": k = sbt_pkg::K_BOOL;
            default: k = (prefix[0] >= "A" && prefix[0] <= "Z") ? sbt_pkg::K_TYPEID
                                                                : sbt_pkg::K_OBJID;
         endcase
         return k;
      endfunction

      function logic [5:0] punct_kind(logic [7:0] c);
         case (c)
            "{": return sbt_pkg::K_LBRACE;   "}": return sbt_pkg::K_RBRACE;
            "[": return sbt_pkg::K_LBRACKET; "]": return sbt_pkg::K_RBRACKET;
            ")": return sbt_pkg::K_RPAREN;   ",": return sbt_pkg::K_COMMA;
            ":": return sbt_pkg::K_COLON;    ".": return sbt_pkg::K_DOT;
            "@": return sbt_pkg::K_AT;       "~": return sbt_pkg::K_TILDE;
            ";": return sbt_pkg::K_SEMI;     "+": return sbt_pkg::K_PLUS;
            "*": return sbt_pkg::K_STAR;     "/": return sbt_pkg::K_SLASH;
            default: return sbt_pkg::K_ERROR;
         endcase
      endfunction

      function bit alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      // Close whatever token was waiting on a lookahead byte.
      function void flush();
         case (mode)
            S_IDENT: emit(classify_word(), run);
            S_INT:   emit(sbt_pkg::K_INT, run);
            S_STR:   emit(sbt_pkg::K_ERROR, run);
            S_LT:    emit(sbt_pkg::K_LT, 1);
            S_EQ:    emit(sbt_pkg::K_EQUAL, 1);
            S_GT:    emit(sbt_pkg::K_GT, 1);
            S_MINUS: emit(sbt_pkg::K_MINUS, 1);
            S_LPAR:  emit(sbt_pkg::K_LPAREN, 1);
            default: ;
         endcase
         mode = S_IDLE;
      endfunction

      function void begin_token(logic [7:0] c);
         mark();
         if (c == " " || c == "\t" || c == "\n") return;
         if (alpha(c)) begin
            mode = S_IDENT; prefix[0] = c; run = 1;
         end else if (digit(c)) begin
            mode = S_INT; run = 1;
         end else if (c == "\"") begin
            mode = S_STR; run = 1; esc = 0;
         end else if (c == "<") mode = S_LT;
         else if (c == "=") mode = S_EQ;
         else if (c == ">") mode = S_GT;
         else if (c == "-") mode = S_MINUS;
         else if (c == "(") mode = S_LPAR;
         else emit(punct_kind(c), 1);
      endfunction

      function void note_byte(logic [7:0] c);
         bit taken;
         taken = 1;
         made.delete();
         byte_count++;
         if (c == 0) begin
            if (mode == S_BLOCK) begin
               mark(); emit(sbt_pkg::K_ERROR, 0); mode = S_IDLE;
            end else flush();
            mark();
            emit(sbt_pkg::K_END, 0);
            clear();
         end else begin
            case (mode)
               S_IDENT: if (alpha(c) || digit(c) || c == "_") begin
                  if (run < 8) prefix[run] = c;
                  run = bump(run);
               end else begin flush(); taken = 0; end
               S_INT: if (digit(c)) run = bump(run);
                  else begin flush(); taken = 0; end
               S_STR: if (esc) begin
                  esc = 0; run = bump(run);
               end else if (c == "\"") begin
                  run = bump(run); emit(sbt_pkg::K_STR, run); mode = S_IDLE;
               end else if (c == "\n") begin
                  flush(); taken = 0;
               end else begin
                  if (c == sbt_pkg::CH_BACKSLASH) esc = 1;
                  run = bump(run);
               end
               S_LT: if (c == "=") begin emit(sbt_pkg::K_LE, 2); mode = S_IDLE; end
                  else if (c == "-") begin emit(sbt_pkg::K_ASSIGN, 2); mode = S_IDLE; end
                  else begin flush(); taken = 0; end
               S_EQ: if (c == ">") begin emit(sbt_pkg::K_DARROW, 2); mode = S_IDLE; end
                  else begin flush(); taken = 0; end
               S_GT: if (c == "=") begin emit(sbt_pkg::K_GE, 2); mode = S_IDLE; end
                  else begin flush(); taken = 0; end
               S_MINUS: if (c == "-") mode = S_LINE;
                  else begin flush(); taken = 0; end
               S_LPAR: if (c == "*") begin
                  mode = S_BLOCK; depth = 1; held = 0;
               end else begin flush(); taken = 0; end
               S_LINE: if (c == "\n") mode = S_IDLE;
               S_BLOCK: if (held == "(" && c == "*") begin
                  if (depth < sbt_pkg::MAX_NESTING) depth++;
                  held = 0;
               end else if (held == "*" && c == ")") begin
                  held = 0;
                  if (depth > 0) depth--;
                  if (depth == 0) mode = S_IDLE;
               end else held = (c == "(" || c == "*") ? c : 8'd0;
               default: begin mode = S_IDLE; taken = 0; end
            endcase
            if (!taken) begin_token(c);
            off = off + 24'd1;
            if (c == "\n") begin line = bump(line); col = 1; end
            else col = bump(col);
         end
         if (made.size() > 0) made[made.size()-1].last = 1;
         foreach (made[i]) pending_tokens.push_back(made[i]);
      endfunction

      function void check_token(sbt_pkg::token_type got);
         sbt_pkg::token_type exp;
         token_count++;
         if (pending_tokens.size() == 0) begin
            errors++;
            $display("%0t: token kind %0d at offset %0d with none expected",
                     $time, got.kind, got.offset);
            return;
         end
         exp = pending_tokens.pop_front();
         if (got.kind !== exp.kind) begin
            errors++; $display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
         end
         if (got.offset !== exp.offset) begin
            errors++; $display("%0t: offset exp %0d got %0d", $time, exp.offset, got.offset);
         end
         if (got.line !== exp.line) begin
            errors++; $display("%0t: line exp %0d got %0d", $time, exp.line, got.line);
         end
         if (got.column !== exp.column) begin
            errors++; $display("%0t: column exp %0d got %0d", $time, exp.column, got.column);
         end
         if (got.length !== exp.length) begin
            errors++; $display("%0t: length exp %0d got %0d", $time, exp.length, got.length);
         end
         if (got.last !== exp.last) begin
            errors++; $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 3000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_token_kind;
   logic [sbt_pkg::OFFSET_BITS-1:0] rsp_token_offset;
   logic [15:0] rsp_token_line, rsp_token_column, rsp_token_length;
   logic        rsp_last_of_run;

   token_scoreboard lexer_sb = new();
   logic [7:0]  text_bytes[$];
   bit          quiet = 0;
   int          idle_cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   source_byte_tokenizer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_token_offset(rsp_token_offset),
      .rsp_token_line(rsp_token_line), .rsp_token_column(rsp_token_column),
      .rsp_token_length(rsp_token_length), .rsp_last_of_run(rsp_last_of_run)
   );

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Token receiver. It checks each accepted beat, then decides the stall for the
   // next cycle: random bursts in busy windows, calm windows with none, and one
   // long hold-off so the token queue fills and the block pushes back on bytes.
   int rx_cycle = 0, hold_left = 0, burst_left = 0;
   bit rx_busy = 1;
   always @(posedge clock) begin
      sbt_pkg::token_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_token_kind; got.offset = rsp_token_offset;
         got.line = rsp_token_line; got.column = rsp_token_column;
         got.length = rsp_token_length; got.last = rsp_last_of_run;
         lexer_sb.check_token(got);
      end
      rx_cycle++;
      if (rx_cycle % 200 == 0) rx_busy = ($urandom_range(0, 2) != 0);
      if (rx_cycle == 150) hold_left = 400;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1;
      end else if (!quiet && rx_busy && $urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 14);
         rsp_stall <= 1;
      end else
         rsp_stall <= 0;
   end

   task automatic add_text(string s);
      foreach (s[i]) text_bytes.push_back(s[i]);
   endtask

   task automatic add_end();
      text_bytes.push_back(8'h00);
   endtask

   function automatic string pick_char(int lo, int hi);
      return string'(8'($urandom_range(lo, hi)));
   endfunction

   // One randomly chosen piece of source text; mostly well formed.
   task automatic add_fragment();
      string kw [21] = '{"class", "else", "fi", "if", "in", "inherits", "isvoid",
         "let", "loop", "pool", "then", "while", "case", "esac", "new", "of",
         "not", "true", "false", "Class", "inheritsX"};
      string ops [7] = '{"<=", "<-", "<", "=", "=>", ">", ">="};
      string puncts = "{}[](),:.@~;+*/-";
      string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
      string s;
      int n;
      s = "";
      case ($urandom_range(0, 12))
         0: s = kw[$urandom_range(0, 20)];
         1: begin
            s = pick_char("a", "z");
            if ($urandom_range(0, 1)) s = pick_char("A", "Z");
            n = $urandom_range(0, 10);
            repeat (n) s = {s, string'(alnum[$urandom_range(0, alnum.len()-1)])};
         end
         2: repeat ($urandom_range(1, 6)) s = {s, pick_char("0", "9")};
         3, 11: begin
            s = "\"";
            repeat ($urandom_range(0, 8)) begin
               if ($urandom_range(0, 4) == 0) begin
                  s = {s, "\\"};
                  case ($urandom_range(0, 2))
                     0: s = {s, "\n"};
                     1: s = {s, "\""};
                     default: s = {s, pick_char(33, 126)};
                  endcase
               end else begin
                  s = {s, pick_char(35, 91)};
               end
            end
            // Sometimes the string is left open at a newline.
            if ($urandom_range(0, 4) == 0) s = {s, "\n"};
            else s = {s, "\""};
         end
         4: s = ops[$urandom_range(0, 6)];
         5: s = string'(puncts[$urandom_range(0, puncts.len()-1)]);
         6: begin
            s = "--";
            repeat ($urandom_range(0, 6)) s = {s, pick_char(32, 126)};
            s = {s, "\n"};
         end
         7: begin
            n = $urandom_range(1, 3);
            repeat (n) s = {s, "(*", pick_char(97, 122)};
            s = {s, "*(", ")"};
            repeat (n) s = {s, "*)"};
         end
         8: s = ($urandom_range(0, 1)) ? " " : (($urandom_range(0, 1)) ? "\t" : "\n");
         9: text_bytes.push_back(8'($urandom_range(1, 255)));
         10: add_end();
         default: s = " ";
      endcase
      add_text(s);
   endtask

   initial begin
      int random_from, quiet_from;
      logic [7:0] b;
      bit gaps;

      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed: an unterminated nested comment, a string with an escaped
      // newline, a string broken by a newline, one open at the end with a
      // trailing backslash, then unknown bytes of both extremes.
      add_text("(*(*x*)"); add_end();
      add_text("\"a\\\nb\"\n\"c\n\"d\\"); add_end();
      text_bytes.push_back(8'hFF); text_bytes.push_back(8'h01);
      add_text("_\t"); add_end();

      random_from = text_bytes.size();
      while (text_bytes.size() - random_from < 620) add_fragment();
      add_end();

      // The tail runs with no idling on either side.
      quiet_from = text_bytes.size();
      while (text_bytes.size() - quiet_from < 100) add_fragment();
      add_end();
      add_text("ok <- 1;"); add_end();

      gaps = 1;
      foreach (text_bytes[i]) begin
         b = text_bytes[i];
         if (i >= quiet_from) quiet = 1;
         if (i % 100 == 0) gaps = ($urandom_range(0, 2) != 0);
         if (!quiet && gaps && $urandom_range(0, 7) == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         req_valid <= 1;
         req_text_byte <= b;
         do @(posedge clock); while (req_stall);
         lexer_sb.note_byte(b);
      end
      req_valid <= 0;

      while (lexer_sb.pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Fed %0d source bytes: keywords, identifiers, numbers, strings, comments,",
               lexer_sb.byte_count);
      $display("operators and error cases; %0d tokens checked, %0d mismatches.",
               lexer_sb.token_count, lexer_sb.errors);
      if (lexer_sb.errors == 0 && lexer_sb.pending_tokens.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
